// ===== hw/rtl/bba_pkg.sv =====
package bba_pkg;

    // Bitmap geometry
    localparam int MAP_BITS  = 4096;
    localparam int WORD_BITS = 32;
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int POS_W     = $clog2(WORD_BITS);
    localparam int MAP_IDX_W = WORD_AW + POS_W;

    // Field widths
    localparam int BLK_W    = 16;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_FIRST_BLOCK = 1'b0;
    localparam logic [BLK_W-1:0] FIRST_BLOCK_RESET = 16'd906;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_FIND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_USE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FREE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_MARK
    } t_state;

endpackage

// ===== hw/rtl/bba_ram.sv =====
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/bitmap_block_allocator.sv =====
// Free-space bitmap allocator: one bit per block, set means used. An item is
// taken when start is high and busy is low; its single result appears for one
// cycle with o_result_valid and cannot be held off, so the receiver must take
// it then. Timing is set by the bitmap memory's one read port: a find reads one
// bitmap word per cycle from word 0 up, up to 128 words; a mark reads the word,
// then writes it back; an out-of-range mark or the unused action code answers
// straight from idle. busy is high until the result is issued, so the next item
// can be accepted in the cycle the result is shown. The bitmap starts all free
// after reset with no clearing pass: a per-word valid bit makes a never-written
// word read as zero. first_block is written over the APB port at byte address
// 0; the user must write it only while the block is idle, which the block
// itself does not enforce.
module bitmap_block_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Command channel
    input  logic                             start,
    output logic                             busy,
    input  logic [bba_pkg::ACTION_W-1:0]     i_action,
    input  logic [bba_pkg::BLK_W-1:0]        i_block_number,
    // Result channel
    output logic                             o_result_valid,
    output logic [bba_pkg::BLK_W-1:0]        o_result_block,
    output logic [bba_pkg::STATUS_W-1:0]     o_status,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bba_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [bba_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [bba_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int BLK_W     = bba_pkg::BLK_W;
    localparam int WORD_BITS = bba_pkg::WORD_BITS;
    localparam int WORD_AW   = bba_pkg::WORD_AW;
    localparam int POS_W     = bba_pkg::POS_W;
    localparam int MAP_IDX_W = bba_pkg::MAP_IDX_W;
    localparam int MAP_WORDS = bba_pkg::MAP_WORDS;
    localparam int STATUS_W  = bba_pkg::STATUS_W;
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);
    localparam logic [BLK_W:0]     MAP_SPAN  = (BLK_W+1)'(bba_pkg::MAP_BITS);

    bba_pkg::t_state r_state, n_state;

    logic [BLK_W-1:0]     r_first_block;
    logic [MAP_WORDS-1:0] r_valid;
    logic [WORD_AW-1:0]   r_word_idx, n_word_idx;
    logic [POS_W-1:0]     r_bit_pos, n_bit_pos;
    logic                 r_set, n_set;
    logic [BLK_W-1:0]     r_blk, n_blk;

    logic                 r_res_valid, n_res_valid;
    logic [BLK_W-1:0]     r_res_block, n_res_block;
    logic [STATUS_W-1:0]  r_res_status, n_res_status;

    logic                 accept;
    logic                 cfg_write;
    logic [BLK_W:0]       diff;
    logic                 out_of_range;
    logic [MAP_IDX_W-1:0] offset;

    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] bit_mask;

    logic                 free_found;
    logic [POS_W-1:0]     free_pos;
    logic [BLK_W:0]       free_block;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == bba_pkg::REG_FIRST_BLOCK)
                       ? bba_pkg::CFG_DATA_W'(r_first_block) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_block <= bba_pkg::FIRST_BLOCK_RESET;
        end else if (cfg_write && paddr[2] == bba_pkg::REG_FIRST_BLOCK) begin
            r_first_block <= pwdata[BLK_W-1:0];
        end
    end

    // Command transfer and mark range check
    assign busy         = (r_state != bba_pkg::S_IDLE);
    assign accept       = start && !busy;
    assign diff         = {1'b0, i_block_number} - {1'b0, r_first_block};
    assign out_of_range = diff[BLK_W] || (diff >= MAP_SPAN);
    assign offset       = diff[MAP_IDX_W-1:0];

    // Bitmap word, with never-written words reading as all free
    assign cur_word = r_valid[r_word_idx] ? rd_data : '0;
    assign bit_mask = WORD_BITS'(1) << r_bit_pos;
    assign wr_data  = r_set ? (cur_word | bit_mask) : (cur_word & ~bit_mask);

    // Lowest clear bit of the current word
    always_comb begin
        free_found = 1'b0;
        free_pos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!cur_word[i]) begin
                free_found = 1'b1;
                free_pos   = POS_W'(i);
            end
        end
    end

    assign free_block = {1'b0, r_first_block} + (BLK_W+1)'({r_word_idx, free_pos});

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_word_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // State register and item context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bba_pkg::S_IDLE;
            r_res_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            if (wr_en) begin
                r_valid[r_word_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word_idx   <= n_word_idx;
        r_bit_pos    <= n_bit_pos;
        r_set        <= n_set;
        r_blk        <= n_blk;
        r_res_block  <= n_res_block;
        r_res_status <= n_res_status;
    end

    // Sequencer: next state, memory access and result
    always_comb begin
        n_state      = r_state;
        n_word_idx   = r_word_idx;
        n_bit_pos    = r_bit_pos;
        n_set        = r_set;
        n_blk        = r_blk;
        n_res_valid  = 1'b0;
        n_res_block  = r_res_block;
        n_res_status = r_res_status;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;

        case (r_state)
            bba_pkg::S_IDLE: begin
                if (accept) begin
                    n_blk = i_block_number;
                    case (i_action)
                        bba_pkg::ACT_FIND: begin
                            // start the scan at word 0
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            n_word_idx = '0;
                            n_state    = bba_pkg::S_FIND;
                        end
                        bba_pkg::ACT_USE, bba_pkg::ACT_FREE: begin
                            if (out_of_range) begin
                                n_res_valid  = 1'b1;
                                n_res_block  = i_block_number;
                                n_res_status = bba_pkg::ST_RANGE;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = offset[MAP_IDX_W-1:POS_W];
                                n_word_idx = offset[MAP_IDX_W-1:POS_W];
                                n_bit_pos  = offset[POS_W-1:0];
                                n_set      = (i_action == bba_pkg::ACT_USE);
                                n_state    = bba_pkg::S_MARK;
                            end
                        end
                        default: begin
                            // unused code: echo and change nothing
                            n_res_valid  = 1'b1;
                            n_res_block  = i_block_number;
                            n_res_status = bba_pkg::ST_OK;
                        end
                    endcase
                end
            end

            bba_pkg::S_FIND: begin
                // examine one word, fetch the next
                rd_en   = 1'b1;
                rd_addr = r_word_idx + 1'b1;
                if (free_found) begin
                    n_res_valid = 1'b1;
                    n_state     = bba_pkg::S_IDLE;
                    if (free_block[BLK_W]) begin
                        n_res_block  = '0;
                        n_res_status = bba_pkg::ST_FULL;
                    end else begin
                        n_res_block  = free_block[BLK_W-1:0];
                        n_res_status = bba_pkg::ST_OK;
                    end
                end else if (r_word_idx == LAST_WORD) begin
                    n_res_valid  = 1'b1;
                    n_res_block  = '0;
                    n_res_status = bba_pkg::ST_FULL;
                    n_state      = bba_pkg::S_IDLE;
                end else begin
                    n_word_idx = r_word_idx + 1'b1;
                end
            end

            bba_pkg::S_MARK: begin
                // write back the modified word
                wr_en        = 1'b1;
                n_res_valid  = 1'b1;
                n_res_block  = r_blk;
                n_res_status = bba_pkg::ST_OK;
                n_state      = bba_pkg::S_IDLE;
            end

            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    assign o_result_valid = r_res_valid;
    assign o_result_block = r_res_block;
    assign o_status       = r_res_status;

endmodule
